// File: design/gdd_pkg.sv
// Shared types, constants and month tables for the Gregorian date difference block.
`default_nettype none

package gdd_pkg;

	localparam int unsigned YEAR_W   = 14;
	localparam int unsigned MONTH_W  = 4;
	localparam int unsigned DAY_W    = 5;
	localparam int unsigned QUOT_W   = 8;
	localparam int unsigned OFS_W    = 9;
	localparam int unsigned DNUM_W   = 22;
	localparam int unsigned DIFF_W   = 23;
	localparam int unsigned PROD_W   = 27;
	localparam int unsigned IN_DATA_W  = 48;
	localparam int unsigned OUT_DATA_W = 24;

	localparam logic [YEAR_W-1:0]  YEAR_MAX    = 14'd9999;
	localparam logic [YEAR_W-1:0]  YEAR_BIAS   = 14'd400;
	localparam logic [MONTH_W-1:0] MONTH_FEB   = 4'd2;
	// Floor of y/100 for any 14-bit y is (y * 5243) >> 19.
	localparam logic [12:0]        RECIP_100   = 13'd5243;
	localparam int unsigned        RECIP_SHIFT = 19;
	localparam logic [6:0]         CENTURY     = 7'd100;
	localparam logic [8:0]         YEAR_DAYS   = 9'd365;

	// Per-date values after the first stage.
	typedef struct packed {
		logic [YEAR_W-1:0]  year;
		logic [YEAR_W-1:0]  yy;
		logic [QUOT_W-1:0]  q_year;
		logic [QUOT_W-1:0]  q_yy;
		logic [OFS_W-1:0]   month_ofs;
		logic [DAY_W-1:0]   day;
		logic [DAY_W-1:0]   month_len;
		logic               feb;
		logic               year_ok;
	} front_t;

	// Per-date values after the second stage.
	typedef struct packed {
		logic [DNUM_W-1:0] dnum;
		logic              ok;
	} back_t;

	// Days in the month for a common year; zero marks a month code that is not a month.
	function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m);
		logic [DAY_W-1:0] len;
		case (m)
			4'd1:    len = 5'd31;
			4'd2:    len = 5'd28;
			4'd3:    len = 5'd31;
			4'd4:    len = 5'd30;
			4'd5:    len = 5'd31;
			4'd6:    len = 5'd30;
			4'd7:    len = 5'd31;
			4'd8:    len = 5'd31;
			4'd9:    len = 5'd30;
			4'd10:   len = 5'd31;
			4'd11:   len = 5'd30;
			4'd12:   len = 5'd31;
			default: len = 5'd0;
		endcase
		return len;
	endfunction

	// Days from March 1 to the first of the month, with the year starting in March.
	function automatic logic [OFS_W-1:0] month_offset(input logic [MONTH_W-1:0] m);
		logic [OFS_W-1:0] ofs;
		case (m)
			4'd3:    ofs = 9'd0;
			4'd4:    ofs = 9'd31;
			4'd5:    ofs = 9'd61;
			4'd6:    ofs = 9'd92;
			4'd7:    ofs = 9'd122;
			4'd8:    ofs = 9'd153;
			4'd9:    ofs = 9'd184;
			4'd10:   ofs = 9'd214;
			4'd11:   ofs = 9'd245;
			4'd12:   ofs = 9'd275;
			4'd1:    ofs = 9'd306;
			4'd2:    ofs = 9'd337;
			default: ofs = 9'd0;
		endcase
		return ofs;
	endfunction

endpackage

`default_nettype wire

// File: design/gregorian_date_difference.sv
// Top level of the Gregorian date difference block: three-stage pipeline and stream ports.
//
//   Channel  Direction  Payload
//   s_axis   in         tdata: year_a, month_a, day_a, year_b, month_b, day_b (48 bits)
//   m_axis   out        tdata: day_difference (23 bits); tuser: invalid_date
//
// Each pair of dates passes three register stages before its result is offered on m_axis.
// A pair can be taken every cycle while the output is not stalled. Stage 1 holds the
// reciprocal multiplies (year / 100), stage 2 the day-number sum with its multiply by 365,
// stage 3 the final subtract.
// A stage moves when the next one is empty or moving, so a stalled output closes bubbles
// before input is held off. Reset clears the valid bits only, not the payload.
`default_nettype none

module gregorian_date_difference (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             s_axis_tvalid,
	output logic                                  s_axis_tready,
	// tdata from bit 0: year_a[13:0], month_a[17:14], day_a[22:18],
	// year_b[36:23], month_b[40:37], day_b[45:41], zero pad [47:46].
	input  wire logic [gdd_pkg::IN_DATA_W-1:0]    s_axis_tdata,
	output logic                                  m_axis_tvalid,
	input  wire logic                             m_axis_tready,
	// tdata from bit 0: day_difference[22:0] (two's complement), zero pad [23].
	output logic [gdd_pkg::OUT_DATA_W-1:0]        m_axis_tdata,
	// tuser: invalid_date.
	output logic                                  m_axis_tuser
);

	// Unpack the two dates from the input transfer.
	logic [gdd_pkg::YEAR_W-1:0]  year_a, year_b;
	logic [gdd_pkg::MONTH_W-1:0] month_a, month_b;
	logic [gdd_pkg::DAY_W-1:0]   day_a, day_b;

	assign year_a  = s_axis_tdata[13:0];
	assign month_a = s_axis_tdata[17:14];
	assign day_a   = s_axis_tdata[22:18];
	assign year_b  = s_axis_tdata[36:23];
	assign month_b = s_axis_tdata[40:37];
	assign day_b   = s_axis_tdata[45:41];

	// Stage valid bits and the ready chain that runs back from the output.
	logic valid_s1, valid_s2, valid_s3;
	logic adv1, adv2, adv3;

	assign adv3          = !valid_s3 || m_axis_tready;
	assign adv2          = !valid_s2 || adv3;
	assign adv1          = !valid_s1 || adv2;
	assign s_axis_tready = adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (adv1) valid_s1 <= s_axis_tvalid;
			if (adv2) valid_s2 <= valid_s1;
			if (adv3) valid_s3 <= valid_s2;
		end
	end

	// Stage 1: year shift, century quotients and month lookups for both dates.
	gdd_pkg::front_t front_a, front_b;
	gdd_pkg::front_t front_a_s1, front_b_s1;

	gdd_date_front u_front_a (
		.year  (year_a),
		.month (month_a),
		.day   (day_a),
		.front (front_a)
	);

	gdd_date_front u_front_b (
		.year  (year_b),
		.month (month_b),
		.day   (day_b),
		.front (front_b)
	);

	always_ff @(posedge clk) begin
		if (adv1) begin
			front_a_s1 <= front_a;
			front_b_s1 <= front_b;
		end
	end

	// Stage 2: leap rule, date checks and serial day numbers.
	gdd_pkg::back_t back_a, back_b;
	gdd_pkg::back_t back_a_s2, back_b_s2;

	gdd_date_back u_back_a (
		.front (front_a_s1),
		.back  (back_a)
	);

	gdd_date_back u_back_b (
		.front (front_b_s1),
		.back  (back_b)
	);

	always_ff @(posedge clk) begin
		if (adv2) begin
			back_a_s2 <= back_a;
			back_b_s2 <= back_b;
		end
	end

	// Stage 3: subtract the day numbers; an invalid pair reports zero days.
	logic                              both_ok;
	logic signed [gdd_pkg::DIFF_W-1:0] diff;
	logic signed [gdd_pkg::DIFF_W-1:0] diff_s3;
	logic                              invalid_s3;

	assign both_ok = back_a_s2.ok && back_b_s2.ok;
	assign diff    = both_ok
		? gdd_pkg::DIFF_W'({1'b0, back_a_s2.dnum}) - gdd_pkg::DIFF_W'({1'b0, back_b_s2.dnum})
		: '0;

	always_ff @(posedge clk) begin
		if (adv3) begin
			diff_s3    <= diff;
			invalid_s3 <= !both_ok;
		end
	end

	assign m_axis_tvalid = valid_s3;
	assign m_axis_tdata  = {1'b0, diff_s3};
	assign m_axis_tuser  = invalid_s3;

`ifndef ASSERT_OFF
	// An invalid pair always carries a zero difference.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
		else $error("invalid result with nonzero difference");

	// A valid difference stays within the span of years 0 to 9999.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |->
		(diff_s3 <= 23'sd3652425) && (diff_s3 >= -23'sd3652425))
		else $error("difference out of range");

	// Input is held off only when every stage is full and the output is stalled.
	assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> valid_s1 && valid_s2 && valid_s3 && !m_axis_tready)
		else $error("input stalled with a free stage");

	// A transfer always lands in the first stage.
	assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> valid_s1)
		else $error("accepted transfer lost at stage 1");
`endif

endmodule

`default_nettype wire

// File: design/gdd_date_front.sv
// First-stage logic for one date: year shift, century quotients and month tables.
`default_nettype none

module gdd_date_front (
	input  wire logic [gdd_pkg::YEAR_W-1:0]  year,
	input  wire logic [gdd_pkg::MONTH_W-1:0] month,
	input  wire logic [gdd_pkg::DAY_W-1:0]   day,
	output gdd_pkg::front_t                   front
);

	logic [gdd_pkg::YEAR_W-1:0] yy;
	logic [gdd_pkg::PROD_W-1:0] prod_y;
	logic [gdd_pkg::PROD_W-1:0] prod_yy;
	logic                       early;

	// January and February count as the tail of the previous year.
	assign early   = (month <= gdd_pkg::MONTH_FEB);
	assign yy      = year + gdd_pkg::YEAR_BIAS - {{(gdd_pkg::YEAR_W-1){1'b0}}, early};
	assign prod_y  = gdd_pkg::PROD_W'(year) * gdd_pkg::PROD_W'(gdd_pkg::RECIP_100);
	assign prod_yy = gdd_pkg::PROD_W'(yy) * gdd_pkg::PROD_W'(gdd_pkg::RECIP_100);

	always_comb begin
		front.year      = year;
		front.yy        = yy;
		front.q_year    = gdd_pkg::QUOT_W'(prod_y >> gdd_pkg::RECIP_SHIFT);
		front.q_yy      = gdd_pkg::QUOT_W'(prod_yy >> gdd_pkg::RECIP_SHIFT);
		front.month_ofs = gdd_pkg::month_offset(month);
		front.day       = day;
		front.month_len = gdd_pkg::month_days(month);
		front.feb       = (month == gdd_pkg::MONTH_FEB);
		front.year_ok   = (year <= gdd_pkg::YEAR_MAX);
	end

endmodule

`default_nettype wire

// File: design/gdd_date_back.sv
// Second-stage logic for one date: leap rule, date check and serial day number.
`default_nettype none

module gdd_date_back (
	input  wire gdd_pkg::front_t front,
	output gdd_pkg::back_t       back
);

	logic [gdd_pkg::YEAR_W-1:0] rem100;
	logic                       leap;
	logic [gdd_pkg::DAY_W:0]    len;
	logic [gdd_pkg::DNUM_W-1:0] base;

	assign rem100 = front.year - gdd_pkg::YEAR_W'(gdd_pkg::YEAR_W'(front.q_year)
		* gdd_pkg::YEAR_W'(gdd_pkg::CENTURY));
	// Every fourth year, except centuries not divisible by four hundred.
	assign leap   = ((front.year[1:0] == 2'd0) && (rem100 != '0))
		|| ((rem100 == '0) && (front.q_year[1:0] == 2'd0));
	assign len    = {1'b0, front.month_len} + {{gdd_pkg::DAY_W{1'b0}}, front.feb & leap};

	assign base = gdd_pkg::DNUM_W'(front.yy) * gdd_pkg::DNUM_W'(gdd_pkg::YEAR_DAYS)
		+ gdd_pkg::DNUM_W'(front.yy >> 2)
		- gdd_pkg::DNUM_W'(front.q_yy)
		+ gdd_pkg::DNUM_W'(front.q_yy >> 2);

	always_comb begin
		back.dnum = base + gdd_pkg::DNUM_W'(front.month_ofs) + gdd_pkg::DNUM_W'(front.day)
			- gdd_pkg::DNUM_W'(1);
		back.ok   = front.year_ok && (front.month_len != '0) && (front.day != '0)
			&& ({1'b0, front.day} <= len);
	end

endmodule

`default_nettype wire

// File: tb/gregorian_date_difference_tb.sv
// Self-checking testbench for the Gregorian date difference block with stream traffic.
module gregorian_date_difference_tb;

	localparam int LAST_YEAR    = 9999;
	localparam int TOP_YEAR     = 16383;	// largest value the 14-bit year field can carry
	localparam int EPOCH_SHIFT  = 400;
	localparam int FEBRUARY     = 2;
	localparam int LONG_HOLD    = 80;
	localparam int DRAIN_CYCLES = 20;
	localparam int RANDOM_PAIRS = 470;
	localparam int MAX_REPORTS  = 100;

	// One calendar date as it sits in tdata; year lands in the low bits.
	typedef struct packed {
		logic [gdd_pkg::DAY_W-1:0]   day;
		logic [gdd_pkg::MONTH_W-1:0] month;
		logic [gdd_pkg::YEAR_W-1:0]  year;
	} date_t;

	// Date A occupies the low half of the payload, date B the high half.
	typedef struct packed {
		date_t b;
		date_t a;
	} date_pair_t;

	typedef struct packed {
		logic                       invalid;
		logic [gdd_pkg::DIFF_W-1:0] diff;
	} day_gap_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [gdd_pkg::IN_DATA_W-1:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [gdd_pkg::OUT_DATA_W-1:0] m_axis_tdata;
	logic m_axis_tuser;

	date_pair_t pair_backlog[$];
	day_gap_t owed_gaps[$];
	int pairs_queued = 0;
	int pairs_taken = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_requests = 0;
	int hold_served = 0;
	int hold_left = 0;
	int errors = 0;
	int real_checked = 0;
	int rejected_checked = 0;
	logic input_took = 1'b0;

	gregorian_date_difference dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic bit leap_year(int y);
		return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
	endfunction

	function automatic int month_length(int y, int m);
		if (m == FEBRUARY)
			return leap_year(y) ? 29 : 28;
		if (m == 4 || m == 6 || m == 9 || m == 11)
			return 30;
		return 31;
	endfunction

	function automatic bit real_date(date_t d);
		if (d.year > LAST_YEAR || d.month < 1 || d.month > 12 || d.day < 1)
			return 1'b0;
		return d.day <= month_length(d.year, d.month);
	endfunction

	// Days since a fixed origin; the year starts in March so the leap day comes last.
	function automatic int serial_day(date_t d);
		int y;
		int m;
		y = d.year + EPOCH_SHIFT - ((d.month <= FEBRUARY) ? 1 : 0);
		m = (d.month + 9) % 12;
		return 365 * y + y / 4 - y / 100 + y / 400 + (153 * m + 2) / 5 + d.day - 1;
	endfunction

	function automatic day_gap_t days_between(date_pair_t p);
		day_gap_t r;
		int span;
		if (!real_date(p.a) || !real_date(p.b)) begin
			r.diff = '0;
			r.invalid = 1'b1;
		end else begin
			span = serial_day(p.a) - serial_day(p.b);
			r.diff = span[gdd_pkg::DIFF_W-1:0];
			r.invalid = 1'b0;
		end
		return r;
	endfunction

	function automatic date_t mk_date(int y, int m, int d);
		date_t r;
		r.year = y[gdd_pkg::YEAR_W-1:0];
		r.month = m[gdd_pkg::MONTH_W-1:0];
		r.day = d[gdd_pkg::DAY_W-1:0];
		return r;
	endfunction

	// A genuine date, leaning toward the ends of the year range and month ends.
	function automatic date_t any_real_date();
		date_t d;
		int pick;
		int len;
		pick = $urandom_range(9);
		if (pick == 0)
			d.year = gdd_pkg::YEAR_W'($urandom_range(3));
		else if (pick == 1)
			d.year = gdd_pkg::YEAR_W'(LAST_YEAR - $urandom_range(3));
		else if (pick == 2)
			d.year = gdd_pkg::YEAR_W'($urandom_range(99) * 100);
		else
			d.year = gdd_pkg::YEAR_W'($urandom_range(LAST_YEAR));
		d.month = gdd_pkg::MONTH_W'($urandom_range(12, 1));
		len = month_length(d.year, d.month);
		d.day = gdd_pkg::DAY_W'(($urandom_range(4) == 0) ? len : $urandom_range(len, 1));
		return d;
	endfunction

	// A date that misses by one field, or plain noise in every field.
	function automatic date_t broken_date();
		date_t d;
		d = any_real_date();
		case ($urandom_range(4))
			0: d.month = gdd_pkg::MONTH_W'($urandom_range(1) ? 0 : $urandom_range(15, 13));
			1: d.day = '0;
			2: d.day = gdd_pkg::DAY_W'(month_length(d.year, d.month) + 1);
			3: d.year = gdd_pkg::YEAR_W'($urandom_range(TOP_YEAR, LAST_YEAR + 1));
			default: begin
				d.year = gdd_pkg::YEAR_W'($urandom_range(TOP_YEAR));
				d.month = gdd_pkg::MONTH_W'($urandom);
				d.day = gdd_pkg::DAY_W'($urandom);
			end
		endcase
		return d;
	endfunction

	task automatic queue_pair(date_t a, date_t b);
		date_pair_t p;
		p.a = a;
		p.b = b;
		pair_backlog.push_back(p);
		pairs_queued++;
	endtask

	task automatic queue_random_pairs(int count);
		int r;
		repeat (count) begin
			r = $urandom_range(99);
			if (r < 80)
				queue_pair(any_real_date(), any_real_date());
			else if (r < 90 && $urandom_range(1))
				queue_pair(broken_date(), any_real_date());
			else if (r < 90)
				queue_pair(any_real_date(), broken_date());
			else
				queue_pair(broken_date(), broken_date());
		end
	endtask

	task automatic wait_all_checked();
		while (pairs_taken != pairs_queued || owed_gaps.size() != 0)
			@(negedge clk);
	endtask

	// Sender: a new pair goes out only once the one on the bus has transferred.
	always @(negedge clk) begin
		if (!s_axis_tvalid || input_took) begin
			if (pair_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				s_axis_tdata <= {{(gdd_pkg::IN_DATA_W - $bits(date_pair_t)){1'b0}},
						pair_backlog.pop_front()};
				s_axis_tvalid <= 1'b1;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// Receiver: random stalls, plus a long hold-off whenever a new one is requested.
	always @(negedge clk) begin
		if (hold_served != hold_requests) begin
			hold_served = hold_requests;
			hold_left = LONG_HOLD;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Both sides are sampled here: transfers in predict, transfers out are checked.
	always @(posedge clk) begin
		day_gap_t want;
		input_took <= arst_n && s_axis_tvalid && s_axis_tready;
		if (arst_n && s_axis_tvalid && s_axis_tready) begin
			owed_gaps.push_back(days_between(date_pair_t'(s_axis_tdata[$bits(date_pair_t)-1:0])));
			pairs_taken++;
		end
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (owed_gaps.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%0t: unexpected result diff=%0d invalid=%0b", $time,
						$signed(m_axis_tdata[gdd_pkg::DIFF_W-1:0]), m_axis_tuser);
			end else begin
				want = owed_gaps.pop_front();
				if (want.invalid)
					rejected_checked++;
				else
					real_checked++;
				// The pad bit above the difference must stay clear.
				if (m_axis_tdata[gdd_pkg::DIFF_W-1:0] !== want.diff
						|| m_axis_tuser !== want.invalid
						|| m_axis_tdata[gdd_pkg::OUT_DATA_W-1:gdd_pkg::DIFF_W] !== '0) begin
					errors++;
					if (errors <= MAX_REPORTS)
						$display("%0t: expected diff=%0d invalid=%0b, got tdata=%h (diff=%0d) invalid=%0b",
							$time, $signed(want.diff), want.invalid, m_axis_tdata,
							$signed(m_axis_tdata[gdd_pkg::DIFF_W-1:0]), m_axis_tuser);
				end
			end
		end
	end

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed pairs: range ends, leap rules, month ends and every way to be invalid.
		queue_pair(mk_date(0, 1, 1), mk_date(0, 1, 1));
		queue_pair(mk_date(LAST_YEAR, 12, 31), mk_date(0, 1, 1));
		queue_pair(mk_date(0, 1, 1), mk_date(LAST_YEAR, 12, 31));
		queue_pair(mk_date(LAST_YEAR, 12, 31), mk_date(LAST_YEAR, 12, 31));
		queue_pair(mk_date(2000, 2, 29), mk_date(2000, 3, 1));
		queue_pair(mk_date(1900, 2, 29), mk_date(1900, 2, 28));
		queue_pair(mk_date(2024, 2, 29), mk_date(2023, 2, 28));
		queue_pair(mk_date(0, 2, 29), mk_date(0, 3, 1));
		queue_pair(mk_date(2023, 1, 1), mk_date(2023, 2, 29));
		queue_pair(mk_date(2100, 2, 28), mk_date(2100, 3, 1));
		queue_pair(mk_date(1999, 12, 31), mk_date(2000, 1, 1));
		queue_pair(mk_date(2023, 1, 31), mk_date(2023, 2, 1));
		queue_pair(mk_date(2020, 11, 30), mk_date(2020, 12, 1));
		queue_pair(mk_date(2020, 0, 10), mk_date(2020, 1, 10));
		queue_pair(mk_date(2020, 13, 1), mk_date(2020, 12, 1));
		queue_pair(mk_date(2020, 1, 1), mk_date(2020, 15, 31));
		queue_pair(mk_date(2020, 5, 0), mk_date(2020, 5, 1));
		queue_pair(mk_date(2021, 4, 31), mk_date(2021, 4, 30));
		queue_pair(mk_date(2020, 6, 15), mk_date(2020, 6, 31));
		queue_pair(mk_date(LAST_YEAR + 1, 1, 1), mk_date(LAST_YEAR, 12, 31));
		queue_pair(mk_date(TOP_YEAR, 15, 31), mk_date(TOP_YEAR, 15, 31));
		queue_pair(mk_date(0, 0, 0), mk_date(0, 0, 0));

		// Full-rate phase, with a long output hold-off to back the pipeline up.
		queue_random_pairs(RANDOM_PAIRS);
		hold_requests++;
		wait_all_checked();

		send_idle_pct = 65;
		queue_random_pairs(RANDOM_PAIRS);
		wait_all_checked();

		send_idle_pct = 0;
		recv_stall_pct = 65;
		queue_random_pairs(RANDOM_PAIRS);
		wait_all_checked();

		send_idle_pct = 7;
		recv_stall_pct = 7;
		queue_random_pairs(RANDOM_PAIRS);
		wait_all_checked();

		// Let any stray result surface before the verdict.
		repeat (DRAIN_CYCLES) @(negedge clk);
		$display("Checked %0d date pairs: %0d real differences and %0d rejected pairs,",
			real_checked + rejected_checked, real_checked, rejected_checked);
		$display("over full-rate, sender-idle, receiver-stall and mixed traffic with a long hold-off.");
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	initial begin
		#2000000;
		$display("simulation failed");
		$finish;
	end

endmodule
